@@ rtl/tile_line_compositor_defines.svh @@
// assertion macros shared by the compositor modules
// no dependencies
`ifndef TILE_LINE_COMPOSITOR_DEFINES_SVH
`define TILE_LINE_COMPOSITOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlc assertion failed");

// next-cycle implication, disabled during reset
`define TLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlc assertion failed");

`endif

@@ rtl/tlc_pkg.sv @@
// shared types, constants and color conversion for the line compositor
// no dependencies
package tlc_pkg;

    localparam int OP_W     = 2;
    localparam int COORD_W  = 8;
    localparam int PAT_W    = 16;
    localparam int DEPTH_W  = 3;
    localparam int COLOR_W  = 12;
    localparam int PIX_W    = 16;
    localparam int REG_IDX_W = 3;
    localparam int WORD_W   = DEPTH_W + PIX_W;
    localparam int PIX_PER_ROW = 8;
    localparam int STEP_W   = $clog2(PIX_PER_ROW);

    localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIN_TOP    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUT_COLOR  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BACK_COLOR = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_NEG_MODE   = 3'd6;

    localparam logic [COORD_W-1:0] WIN_WIDTH_RST  = 8'd160;
    localparam logic [COORD_W-1:0] WIN_HEIGHT_RST = 8'd152;
    localparam logic [COORD_W-1:0] NEG_X_THRESH   = 8'hF8;
    localparam logic [STEP_W-1:0]  LAST_STEP      = STEP_W'(PIX_PER_ROW - 1);

    typedef struct packed {
        logic [COORD_W-1:0] line_number;
        logic [COORD_W-1:0] screen_x;
        logic [PAT_W-1:0]   pattern_bits;
        logic               mirror;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] colour_one;
        logic [COLOR_W-1:0] colour_two;
        logic [COLOR_W-1:0] colour_three;
        logic [COORD_W-1:0] pixel_index;
    } t_in_item;

    typedef struct packed {
        logic load_begin;
        logic load_draw;
        logic load_read;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_done;
    } t_dp_stat;

    // 12-bit 0xRGB to 5-6-5, r in the low bits
    function automatic logic [PIX_W-1:0] to565(input logic [COLOR_W-1:0] c,
                                               input logic neg);
        logic [3:0] r;
        logic [3:0] g;
        logic [3:0] b;
        logic [4:0] r5;
        logic [4:0] b5;
        logic [5:0] g6;
        logic [5:0] g_fifth;
        logic [PIX_W-1:0] v;
        r = c[11:8];
        g = c[7:4];
        b = c[3:0];
        r5 = (r == 4'hF) ? 5'd31 : {r, 1'b0};
        b5 = (b == 4'hF) ? 5'd31 : {b, 1'b0};
        if (g == 4'hF) begin
            g_fifth = 6'd3;
        end else if (g >= 4'd10) begin
            g_fifth = 6'd2;
        end else if (g >= 4'd5) begin
            g_fifth = 6'd1;
        end else begin
            g_fifth = 6'd0;
        end
        g6 = {g, 2'b00} + g_fifth;
        v = {b5, g6, r5};
        return neg ? ~v : v;
    endfunction

endpackage

@@ rtl/tlc_in_if.sv @@
// input item channel of the line compositor
// depends on tlc_pkg
interface tlc_in_if;
    logic                          valid;
    logic                          ready;
    logic [tlc_pkg::OP_W-1:0]      op;
    logic [tlc_pkg::COORD_W-1:0]   line_number;
    logic [tlc_pkg::COORD_W-1:0]   screen_x;
    logic [tlc_pkg::PAT_W-1:0]     pattern_bits;
    logic                          mirror;
    logic [tlc_pkg::DEPTH_W-1:0]   depth;
    logic [tlc_pkg::COLOR_W-1:0]   colour_one;
    logic [tlc_pkg::COLOR_W-1:0]   colour_two;
    logic [tlc_pkg::COLOR_W-1:0]   colour_three;
    logic [tlc_pkg::COORD_W-1:0]   pixel_index;

    modport source (output valid, op, line_number, screen_x, pattern_bits, mirror, depth,
                    colour_one, colour_two, colour_three, pixel_index, input ready);
    modport sink (input valid, op, line_number, screen_x, pattern_bits, mirror, depth,
                  colour_one, colour_two, colour_three, pixel_index, output ready);
endinterface

@@ rtl/tlc_out_if.sv @@
// result channel of the line compositor
// depends on tlc_pkg
interface tlc_out_if;
    logic                        valid;
    logic                        ready;
    logic [tlc_pkg::PIX_W-1:0]   pixel_colour;

    modport source (output valid, pixel_colour, input ready);
    modport sink (input valid, pixel_colour, output ready);
endinterface

@@ rtl/tlc_cfg_if.sv @@
// register write channel of the line compositor
// depends on tlc_pkg
interface tlc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tlc_pkg::REG_IDX_W-1:0] index;
    logic [tlc_pkg::COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tlc_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module tlc_ram #(
    parameter int WIDTH  = 19,
    parameter int DEPTH  = 160,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/tlc_ctrl.sv @@
// sequencer of the line compositor: accepts items, steps pattern pixels
// depends on tlc_pkg and tile_line_compositor_defines.svh
module tlc_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [tlc_pkg::OP_W-1:0] i_op,
    output logic                     o_ready,
    output tlc_pkg::t_dp_cmd         o_cmd,
    input  tlc_pkg::t_dp_stat        i_stat
);
    import tlc_pkg::*;
    `include "tile_line_compositor_defines.svh"

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DRAW  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_READ  = 5'b01000,
        S_OUT   = 5'b10000
    } t_ctl_state;

    t_ctl_state       r_state;
    t_ctl_state       n_state;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] n_cnt;
    logic             accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_BEGIN: begin
                            o_cmd.load_begin = 1'b1;
                        end
                        OP_DRAW: begin
                            o_cmd.load_draw = 1'b1;
                            n_cnt   = '0;
                            n_state = S_DRAW;
                        end
                        OP_READ: begin
                            o_cmd.load_read = 1'b1;
                            n_state = S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAW: begin
                o_cmd.issue = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                o_cmd.load_out = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `TLC_ASSERT_NXT(a_draw_starts, i_clk, i_rst_n,
                    accept && (i_op == OP_DRAW), r_state == S_DRAW)
    `TLC_ASSERT_NXT(a_draw_ends, i_clk, i_rst_n,
                    (r_state == S_DRAW) && (r_cnt == LAST_STEP), r_state == S_FLUSH)
    `TLC_ASSERT_NXT(a_out_holds, i_clk, i_rst_n,
                    (r_state == S_OUT) && !i_stat.out_done, r_state == S_OUT)
endmodule

@@ rtl/tlc_datapath.sv @@
// line buffer datapath: config registers, fill flags, depth test, read-out register
// depends on tlc_pkg, tlc_ram and tile_line_compositor_defines.svh
module tlc_datapath #(
    parameter int LINE_WIDTH = 160
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlc_pkg::t_dp_cmd              i_cmd,
    output tlc_pkg::t_dp_stat             o_stat,
    input  tlc_pkg::t_in_item             i_item,
    input  logic                          i_cfg_we,
    input  logic [tlc_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [tlc_pkg::COLOR_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tlc_pkg::PIX_W-1:0]     o_pixel_colour
);
    import tlc_pkg::*;
    `include "tile_line_compositor_defines.svh"

    localparam int AW = $clog2(LINE_WIDTH);
    localparam int POS_W = COORD_W + 2;
    localparam logic [COORD_W:0] LW9 = (COORD_W + 1)'(LINE_WIDTH);

    // config registers
    logic [COORD_W-1:0] r_win_left;
    logic [COORD_W-1:0] r_win_top;
    logic [COORD_W-1:0] r_win_width;
    logic [COORD_W-1:0] r_win_height;
    logic [COLOR_W-1:0] r_out_color;
    logic [COLOR_W-1:0] r_back_color;
    logic               r_neg;

    // line state captured at begin line
    logic               r_active;
    logic [PIX_W-1:0]   r_fill_out;
    logic [PIX_W-1:0]   r_fill_back;
    logic [COORD_W-1:0] r_lo;
    logic [COORD_W:0]   r_hi;
    logic [LINE_WIDTH-1:0] r_drawn;

    // draw row state
    logic                    r_draw_ok;
    logic signed [POS_W-1:0] r_pos;
    logic [PAT_W-1:0]        r_bits;
    logic [DEPTH_W-1:0]      r_depth;
    logic [COLOR_W-1:0]      r_col1;
    logic [COLOR_W-1:0]      r_col2;
    logic [COLOR_W-1:0]      r_col3;

    // write-back stage
    logic          r_s2_en;
    logic [AW-1:0] r_s2_addr;
    logic [1:0]    r_s2_v;

    // read path
    logic [COORD_W-1:0] r_rd_idx;
    logic               r_rd_in_range;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pix;

    logic [COORD_W:0]        win_right;
    logic [COORD_W:0]        line_end;
    logic                    line_in;
    logic signed [POS_W-1:0] start_x;
    logic                    start_ok;
    logic [PAT_W-1:0]        mirrored;
    logic [1:0]              cur_v;
    logic                    s1_en;
    logic [DEPTH_W-1:0]      stored_depth;
    logic [COLOR_W-1:0]      wr_color;
    logic                    ram_we;
    logic [WORD_W-1:0]       ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [WORD_W-1:0]       ram_rdata;
    logic [PIX_W-1:0]        fill_pix;
    logic [PIX_W-1:0]        rd_pix;

    assign win_right = {1'b0, r_win_left} + {1'b0, r_win_width};
    assign line_end  = {1'b0, r_win_top} + {1'b0, r_win_height};
    assign line_in   = (i_item.line_number >= r_win_top) &&
                       ({1'b0, i_item.line_number} < line_end);

    assign start_x  = (i_item.screen_x > NEG_X_THRESH) ? {2'b11, i_item.screen_x}
                                                      : {2'b00, i_item.screen_x};
    assign start_ok = r_active && (start_x[POS_W-1] || (start_x[COORD_W:0] < LW9));

    always_comb begin
        mirrored = i_item.pattern_bits;
        if (i_item.mirror) begin
            for (int i = 0; i < PIX_PER_ROW; i++) begin
                mirrored[2*i +: 2] = i_item.pattern_bits[2*(PIX_PER_ROW-1-i) +: 2];
            end
        end
    end

    // leftmost pending pixel sits in the top pair
    assign cur_v = r_bits[PAT_W-1 -: 2];
    assign s1_en = r_draw_ok && (cur_v != 2'd0) && !r_pos[POS_W-1] &&
                   (r_pos[COORD_W:0] >= {1'b0, r_win_left}) &&
                   (r_pos[COORD_W:0] < win_right) && (r_pos[COORD_W:0] < LW9);

    assign ram_raddr = i_cmd.issue ? r_pos[AW-1:0] : i_item.pixel_index[AW-1:0];

    assign stored_depth = r_drawn[r_s2_addr] ? ram_rdata[PIX_W +: DEPTH_W] : '0;

    always_comb begin
        case (r_s2_v)
            2'd1:    wr_color = r_col1;
            2'd2:    wr_color = r_col2;
            default: wr_color = r_col3;
        endcase
    end

    assign ram_we    = r_s2_en && (r_depth > stored_depth);
    assign ram_wdata = {r_depth, to565(wr_color, r_neg)};

    tlc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LINE_WIDTH),
        .ADDR_W(AW)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_s2_addr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign fill_pix = (r_active && (r_rd_idx >= r_lo) && ({1'b0, r_rd_idx} < r_hi))
                      ? r_fill_back : r_fill_out;
    assign rd_pix = !r_rd_in_range ? '0 :
                    r_drawn[r_rd_idx[AW-1:0]] ? ram_rdata[PIX_W-1:0] : fill_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_top    <= '0;
            r_win_width  <= WIN_WIDTH_RST;
            r_win_height <= WIN_HEIGHT_RST;
            r_out_color  <= '0;
            r_back_color <= '0;
            r_neg        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIN_LEFT:   r_win_left   <= i_cfg_data[COORD_W-1:0];
                REG_WIN_TOP:    r_win_top    <= i_cfg_data[COORD_W-1:0];
                REG_WIN_WIDTH:  r_win_width  <= i_cfg_data[COORD_W-1:0];
                REG_WIN_HEIGHT: r_win_height <= i_cfg_data[COORD_W-1:0];
                REG_OUT_COLOR:  r_out_color  <= i_cfg_data;
                REG_BACK_COLOR: r_back_color <= i_cfg_data;
                REG_NEG_MODE:   r_neg        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_fill_out  <= '0;
            r_fill_back <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_drawn     <= '0;
        end else if (i_cmd.load_begin) begin
            r_active    <= line_in;
            r_fill_out  <= to565(r_out_color, r_neg);
            r_fill_back <= to565(r_back_color, r_neg);
            r_lo        <= r_win_left;
            r_hi        <= win_right;
            r_drawn     <= '0;
        end else if (ram_we) begin
            r_drawn[r_s2_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_draw) begin
            r_pos   <= start_x;
            r_bits  <= mirrored;
            r_depth <= i_item.depth;
            r_col1  <= i_item.colour_one;
            r_col2  <= i_item.colour_two;
            r_col3  <= i_item.colour_three;
        end else if (i_cmd.issue) begin
            r_pos  <= r_pos + $signed(POS_W'(1));
            r_bits <= {r_bits[PAT_W-3:0], 2'b00};
        end
        if (i_cmd.issue) begin
            r_s2_addr <= r_pos[AW-1:0];
            r_s2_v    <= cur_v;
        end
        if (i_cmd.load_read) begin
            r_rd_idx      <= i_item.pixel_index;
            r_rd_in_range <= {1'b0, i_item.pixel_index} < LW9;
        end
        if (i_cmd.load_out) begin
            r_out_pix <= rd_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_ok   <= 1'b0;
            r_s2_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_draw) begin
                r_draw_ok <= start_ok;
            end
            r_s2_en <= i_cmd.issue && s1_en;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pixel_colour  = r_out_pix;
    assign o_stat.out_done = r_out_valid && i_ready;

    `TLC_ASSERT_IMP(a_no_result_overwrite, i_clk, i_rst_n, i_cmd.load_out, !r_out_valid)
    `TLC_ASSERT_IMP(a_begin_no_pending_write, i_clk, i_rst_n, i_cmd.load_begin, !r_s2_en)
    `TLC_ASSERT_IMP(a_draw_no_pending_result, i_clk, i_rst_n, i_cmd.issue, !r_out_valid)
endmodule

@@ rtl/tile_line_compositor.sv @@
// scanline compositor: 2bpp pattern rows into a depth-tested line buffer, one item at a time
// begin line leaves the sequencer idle; a pattern row steps one pixel a cycle, then a flush state
// read pixel: ram read, then the result register; input ready again after the result beat
// config beats are always taken: the config ready is tied high
// synchronous active-low reset loads config defaults, clears line flags and result valid
module tile_line_compositor #(
    parameter int LINE_WIDTH = 160
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlc_in_if.sink    i_in,
    tlc_out_if.source o_out,
    tlc_cfg_if.sink   i_cfg
);
    import tlc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_in_item item;
    logic     ctl_ready;

    assign item.line_number  = i_in.line_number;
    assign item.screen_x     = i_in.screen_x;
    assign item.pattern_bits = i_in.pattern_bits;
    assign item.mirror       = i_in.mirror;
    assign item.depth        = i_in.depth;
    assign item.colour_one   = i_in.colour_one;
    assign item.colour_two   = i_in.colour_two;
    assign item.colour_three = i_in.colour_three;
    assign item.pixel_index  = i_in.pixel_index;

    assign i_in.ready  = ctl_ready;
    assign i_cfg.ready = 1'b1;

    tlc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in.valid),
        .i_op   (i_in.op),
        .o_ready(ctl_ready),
        .o_cmd  (cmd),
        .i_stat (stat)
    );

    tlc_datapath #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_item        (item),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_pixel_colour(o_out.pixel_colour)
    );
endmodule

@@ tb/sv/tb_top.sv @@
// self-checking bench for tile_line_compositor: begin-line, pattern-row and pixel-read traffic
// predicts the line buffer and depth buffer, compares every pixel read beat
// depends on tlc_pkg, tlc_in_if, tlc_out_if, tlc_cfg_if and the compositor rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tlc_pkg::*;

    localparam int LINE_W = 160;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_in_item        body;
    } t_line_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlc_in_if  in_if();
    tlc_out_if out_if();
    tlc_cfg_if cfg_if();

    tile_line_compositor #(.LINE_WIDTH(LINE_W)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // predicted line state and register copies
    logic [PIX_W-1:0]   line_pix [LINE_W];
    logic [DEPTH_W-1:0] line_dep [LINE_W];
    logic               line_on;
    logic [COORD_W-1:0] cur_left, cur_top, cur_width, cur_height;
    logic [COLOR_W-1:0] cur_outside, cur_backdrop;
    logic               cur_negative;

    t_line_cmd        line_cmds [$];
    logic [PIX_W-1:0] expected_pixels [$];
    t_line_cmd        next_cmd;
    logic [PIX_W-1:0] want;

    int  cmds_pushed = 0;
    int  cmds_taken = 0;
    int  pixels_seen = 0;
    int  err_count = 0;
    int  setting_count = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    bit  in_taken = 1'b0;

    always #4 i_clk = ~i_clk;

    function automatic logic [PIX_W-1:0] bgr_to_565(logic [COLOR_W-1:0] c);
        int r, g, b;
        logic [PIX_W-1:0] v;
        r = int'(c[11:8]) * 31 / 15;
        g = int'(c[7:4]) * 63 / 15;
        b = int'(c[3:0]) * 31 / 15;
        v = PIX_W'(r | (g << 5) | (b << 11));
        return cur_negative ? ~v : v;
    endfunction

    task automatic compose_begin_line(logic [COORD_W-1:0] ln);
        logic [PIX_W-1:0] outc, backc;
        int lo, hi;
        outc = bgr_to_565(cur_outside);
        backc = bgr_to_565(cur_backdrop);
        lo = int'(cur_left);
        hi = int'(cur_left) + int'(cur_width);
        if (hi > LINE_W) hi = LINE_W;
        line_on = (int'(ln) >= int'(cur_top)) && (int'(ln) < int'(cur_top) + int'(cur_height));
        for (int x = 0; x < LINE_W; x++) begin
            line_dep[x] = '0;
            line_pix[x] = (line_on && x >= lo && x < hi) ? backc : outc;
        end
    endtask

    task automatic compose_draw_row(logic [COORD_W-1:0] sx, logic [PAT_W-1:0] pat, logic mir,
                                    logic [DEPTH_W-1:0] dp, logic [COLOR_W-1:0] c1,
                                    logic [COLOR_W-1:0] c2, logic [COLOR_W-1:0] c3);
        int x, left, right, highmark, drop;
        logic [PAT_W-1:0]   bits;
        logic [1:0]         v;
        logic [COLOR_W-1:0] shade;
        if (!line_on) return;
        x = int'(sx);
        if (x > int'(NEG_X_THRESH)) x -= 256;
        if (x >= LINE_W) return;
        bits = pat;
        if (mir) begin
            for (int i = 0; i < 8; i++) bits[2*(7-i) +: 2] = pat[2*i +: 2];
        end
        left = x;
        if (int'(cur_left) > left) left = int'(cur_left);
        if (left < 0) left = 0;
        right = x + 7;
        highmark = int'(cur_left) + int'(cur_width);
        if (highmark > LINE_W) highmark = LINE_W;
        highmark -= 1;
        if (right > highmark) begin
            drop = right - highmark;
            bits = (drop >= 8) ? '0 : bits >> (2 * drop);
            right = highmark;
        end
        for (int xx = right; xx >= left; xx--) begin
            v = bits[1:0];
            bits = bits >> 2;
            if (xx < 0 || xx >= LINE_W) continue;
            if (v == 2'd0 || dp <= line_dep[xx]) continue;
            case (v)
                2'd1: shade = c1;
                2'd2: shade = c2;
                default: shade = c3;
            endcase
            line_dep[xx] = dp;
            line_pix[xx] = bgr_to_565(shade);
        end
    endtask

    // stimulus helpers
    function automatic t_in_item random_body();
        t_in_item b;
        b.line_number  = COORD_W'($urandom_range(255));
        b.screen_x     = COORD_W'($urandom_range(255));
        b.pattern_bits = PAT_W'($urandom_range(65535));
        b.mirror       = 1'($urandom_range(1));
        b.depth        = DEPTH_W'($urandom_range(7));
        b.colour_one   = COLOR_W'($urandom_range(4095));
        b.colour_two   = COLOR_W'($urandom_range(4095));
        b.colour_three = COLOR_W'($urandom_range(4095));
        b.pixel_index  = COORD_W'($urandom_range(255));
        return b;
    endfunction

    function automatic void push_cmd(logic [OP_W-1:0] op, t_in_item b);
        t_line_cmd c;
        c.op = op;
        c.body = b;
        line_cmds.push_back(c);
        cmds_pushed++;
    endfunction

    function automatic void push_begin(logic [COORD_W-1:0] ln);
        t_in_item b;
        b = random_body();
        b.line_number = ln;
        push_cmd(OP_BEGIN, b);
    endfunction

    function automatic void push_read(logic [COORD_W-1:0] idx);
        t_in_item b;
        b = random_body();
        b.pixel_index = idx;
        push_cmd(OP_READ, b);
    endfunction

    function automatic void push_draw(logic [COORD_W-1:0] sx, logic [PAT_W-1:0] pat, logic mir,
                                      logic [DEPTH_W-1:0] dp, logic [COLOR_W-1:0] c1,
                                      logic [COLOR_W-1:0] c2, logic [COLOR_W-1:0] c3);
        t_in_item b;
        b = random_body();
        b.screen_x = sx;
        b.pattern_bits = pat;
        b.mirror = mir;
        b.depth = dp;
        b.colour_one = c1;
        b.colour_two = c2;
        b.colour_three = c3;
        push_cmd(OP_DRAW, b);
    endfunction

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // unused upper data bits get random content
    task automatic set_window(int l, int t, int w, int h, logic [COLOR_W-1:0] oc,
                              logic [COLOR_W-1:0] bc, bit ng);
        write_reg(REG_WIN_LEFT, COLOR_W'(l) | (COLOR_W'($urandom_range(15)) << 8));
        write_reg(REG_WIN_TOP, COLOR_W'(t) | (COLOR_W'($urandom_range(15)) << 8));
        write_reg(REG_WIN_WIDTH, COLOR_W'(w) | (COLOR_W'($urandom_range(15)) << 8));
        write_reg(REG_WIN_HEIGHT, COLOR_W'(h) | (COLOR_W'($urandom_range(15)) << 8));
        write_reg(REG_OUT_COLOR, oc);
        write_reg(REG_BACK_COLOR, bc);
        write_reg(REG_NEG_MODE, COLOR_W'(ng) | (COLOR_W'($urandom_range(2047)) << 1));
        setting_count++;
    endtask

    task automatic settle();
        while (cmds_taken != cmds_pushed || expected_pixels.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // mostly whole lines: begin, a few pattern rows, a few reads; the rest is noise
    task automatic make_traffic(int target);
        int made, n, lo, hi, x, col, pick;
        t_in_item b;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                if (cur_height != 0 && $urandom_range(9) < 8) begin
                    x = int'(cur_top) + $urandom_range(int'(cur_height) - 1);
                    if (x > 255) x = $urandom_range(255);
                end else begin
                    x = $urandom_range(255);
                end
                push_begin(COORD_W'(x));
                lo = int'(cur_left) - 7;
                hi = int'(cur_left) + int'(cur_width);
                if (hi > LINE_W) hi = LINE_W;
                hi -= 1;
                n = $urandom_range(6, 1);
                repeat (n) begin
                    pick = $urandom_range(9);
                    if (pick < 6 && hi >= lo) begin
                        x = lo + $urandom_range(hi - lo);
                    end else if (pick < 8) begin
                        x = $urandom_range(1) ? $urandom_range(255, 249) : $urandom_range(166, 150);
                    end else begin
                        x = $urandom_range(255);
                    end
                    push_draw(COORD_W'(x), PAT_W'($urandom_range(65535)), 1'($urandom_range(1)),
                              DEPTH_W'($urandom_range(7)), COLOR_W'($urandom_range(4095)),
                              COLOR_W'($urandom_range(4095)), COLOR_W'($urandom_range(4095)));
                end
                made += n + 1;
                n = $urandom_range(4, 1);
                repeat (n) begin
                    pick = $urandom_range(19);
                    if (pick < 12 && hi >= int'(cur_left)) begin
                        col = int'(cur_left) + $urandom_range(hi - int'(cur_left));
                    end else if (pick < 17) begin
                        col = $urandom_range(LINE_W - 1);
                    end else begin
                        col = $urandom_range(255);
                    end
                    push_read(COORD_W'(col));
                end
                made += n;
            end else if (pick < 90) begin
                push_cmd(OP_UNUSED, random_body());
            end else begin
                b = random_body();
                case ($urandom_range(2))
                    0: push_cmd(OP_BEGIN, b);
                    1: push_cmd(OP_DRAW, b);
                    default: push_cmd(OP_READ, b);
                endcase
                made++;
            end
        end
    endtask

    // item driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (line_cmds.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
                next_cmd = line_cmds.pop_front();
                in_if.op <= next_cmd.op;
                in_if.line_number <= next_cmd.body.line_number;
                in_if.screen_x <= next_cmd.body.screen_x;
                in_if.pattern_bits <= next_cmd.body.pattern_bits;
                in_if.mirror <= next_cmd.body.mirror;
                in_if.depth <= next_cmd.body.depth;
                in_if.colour_one <= next_cmd.body.colour_one;
                in_if.colour_two <= next_cmd.body.colour_two;
                in_if.colour_three <= next_cmd.body.colour_three;
                in_if.pixel_index <= next_cmd.body.pixel_index;
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // pixel receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= 29);
        end
    end

    // long receiver stall, which also holds off the input once a read is pending
    initial begin
        wait (cmds_taken >= 300);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    // monitor and checker
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_WIN_LEFT:   cur_left = cfg_if.data[COORD_W-1:0];
                    REG_WIN_TOP:    cur_top = cfg_if.data[COORD_W-1:0];
                    REG_WIN_WIDTH:  cur_width = cfg_if.data[COORD_W-1:0];
                    REG_WIN_HEIGHT: cur_height = cfg_if.data[COORD_W-1:0];
                    REG_OUT_COLOR:  cur_outside = cfg_if.data;
                    REG_BACK_COLOR: cur_backdrop = cfg_if.data;
                    REG_NEG_MODE:   cur_negative = cfg_if.data[0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                cmds_taken++;
                case (in_if.op)
                    OP_BEGIN: compose_begin_line(in_if.line_number);
                    OP_DRAW: compose_draw_row(in_if.screen_x, in_if.pattern_bits, in_if.mirror,
                                              in_if.depth, in_if.colour_one, in_if.colour_two,
                                              in_if.colour_three);
                    OP_READ: expected_pixels.push_back(in_if.pixel_index < LINE_W ?
                                                       line_pix[in_if.pixel_index] : PIX_W'(0));
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    if (err_count < 10)
                        $display("tb_top: pixel beat with none pending, got %h",
                                 out_if.pixel_colour);
                    err_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_if.pixel_colour !== want) begin
                        if (err_count < 10)
                            $display("tb_top: pixel_colour mismatch at %0t: expected %h, got %h",
                                     $realtime, want, out_if.pixel_colour);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = OP_BEGIN;
        in_if.line_number = '0;
        in_if.screen_x = '0;
        in_if.pattern_bits = '0;
        in_if.mirror = 1'b0;
        in_if.depth = '0;
        in_if.colour_one = '0;
        in_if.colour_two = '0;
        in_if.colour_three = '0;
        in_if.pixel_index = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_WIN_LEFT;
        cfg_if.data = '0;
        cur_left = '0;
        cur_top = '0;
        cur_width = WIN_WIDTH_RST;
        cur_height = WIN_HEIGHT_RST;
        cur_outside = '0;
        cur_backdrop = '0;
        cur_negative = 1'b0;
        line_on = 1'b0;
        for (int x = 0; x < LINE_W; x++) begin
            line_pix[x] = '0;
            line_dep[x] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads before any line, inactive lines, window edges, clipping, depth
        set_window(4, 2, 150, 100, 12'hF0F, 12'h5A3, 1'b0);
        push_read(8'd0);
        push_read(8'd255);
        push_draw(8'd10, 16'hFFFF, 1'b0, 3'd7, 12'hFFF, 12'hFFF, 12'hFFF);
        push_cmd(OP_UNUSED, random_body());
        push_begin(8'd0);
        push_read(8'd10);
        push_begin(8'd101);
        push_read(8'd3);
        push_read(8'd153);
        push_read(8'd154);
        push_draw(8'd0, 16'hFFFF, 1'b0, 3'd7, 12'h000, 12'h000, 12'hFFF);
        push_draw(8'hF9, 16'hFFFF, 1'b0, 3'd7, 12'h123, 12'h456, 12'h789);
        push_draw(8'hF8, 16'hFFFF, 1'b0, 3'd7, 12'h123, 12'h456, 12'h789);
        push_draw(8'd150, 16'hE4E4, 1'b0, 3'd1, 12'h00F, 12'h0F0, 12'hF00);
        push_draw(8'd150, 16'hFFFF, 1'b1, 3'd0, 12'hABC, 12'hABC, 12'hABC);
        push_draw(8'd150, 16'h5555, 1'b0, 3'd1, 12'h321, 12'h654, 12'h987);
        push_draw(8'd150, 16'h1B1B, 1'b1, 3'd2, 12'hA5A, 12'h5A5, 12'hFF0);
        push_draw(8'd159, 16'hFFFF, 1'b0, 3'd7, 12'hFFF, 12'hFFF, 12'hFFF);
        push_draw(8'd160, 16'hFFFF, 1'b0, 3'd7, 12'hFFF, 12'hFFF, 12'hFFF);
        push_read(8'd4);
        push_read(8'd150);
        push_read(8'd152);
        push_read(8'd159);
        push_read(8'd160);
        push_begin(8'd102);
        settle();

        set_window(0, 0, 255, 255, 12'hFFF, 12'h000, 1'b1);
        make_traffic(130);
        settle();

        set_window(255, 255, 0, 0, 12'h000, 12'hFFF, 1'b0);
        make_traffic(60);
        settle();

        calm = 1'b1;
        set_window(0, 10, 160, 140, COLOR_W'($urandom_range(4095)),
                   COLOR_W'($urandom_range(4095)), 1'b0);
        make_traffic(140);
        settle();
        calm = 1'b0;

        set_window(40, 0, 80, 60, COLOR_W'($urandom_range(4095)),
                   COLOR_W'($urandom_range(4095)), 1'b1);
        make_traffic(130);
        settle();

        repeat (2) begin
            set_window($urandom_range(60), $urandom_range(100), $urandom_range(255, 8),
                       $urandom_range(255, 1), COLOR_W'($urandom_range(4095)),
                       COLOR_W'($urandom_range(4095)), 1'($urandom_range(1)));
            make_traffic(120);
            settle();
        end

        $display("tb_top: %0d commands taken, %0d pixels read back under %0d window setups",
                 cmds_taken, pixels_seen, setting_count);
        $display("tb_top: %0d failures seen", err_count);
        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_in_if.sv
rtl/tlc_out_if.sv
rtl/tlc_cfg_if.sv
rtl/tlc_ram.sv
rtl/tlc_ctrl.sv
rtl/tlc_datapath.sv
rtl/tile_line_compositor.sv
tb/sv/tb_top.sv
